// ===== src/aroc_pkg.sv =====
`timescale 1ns / 1ps

package aroc_pkg;

  localparam int unsigned CapacityDef = 512;
  localparam int unsigned CountW      = 10;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] start_angle;
    logic [31:0] end_angle;
  } in_item_t;

  typedef struct packed {
    logic              visible;
    logic              dropped;
    logic [CountW-1:0] range_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic part;
    logic eval;
    logic w2;
    logic end_part;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_op;
    logic wrap;
    logic scan_end;
    logic need_w2;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== src/angle_range_occlusion_clipper.sv =====
`timescale 1ns / 1ps
// Channel | Signals                          | Payload
// input   | in_valid_i / in_ready_o          | in_data_i  (cmd, start_angle, end_angle)
// output  | out_valid_o / out_ready_i        | out_data_o (visible, dropped, range_count)
//
// Clear and unused commands go straight to the final state. Add and check scan the
// stored list once per part, reading then evaluating each entry (plus a second write
// step for the entry after an insertion); a wrapped range runs two parts.
// The scan rate is set by the registered read of the range memory.
// Reset empties the list at once; no clearing pass. A stalled output holds the
// controller in its final state; a new item is taken only when the block is idle.

module angle_range_occlusion_clipper #(
  parameter int unsigned CAPACITY = aroc_pkg::CapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aroc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aroc_pkg::out_item_t out_data_o
);

  aroc_pkg::ctrl_cmd_t cmd;
  aroc_pkg::ctrl_sts_t sts;

  aroc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aroc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== src/aroc_ctrl.sv =====
`timescale 1ns / 1ps

module aroc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aroc_pkg::ctrl_sts_t sts_i,
  output aroc_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_W2    = 3'd4;
  localparam logic [2:0] S_ENDP  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       part_q, part_d;

  assign in_ready_o = (state_q == S_IDLE);

  // sequence the scan passes
  always_comb begin
    state_d = state_q;
    part_d  = part_q;
    cmd_o   = '0;
    cmd_o.part = part_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          part_d     = 1'b0;
          state_d    = sts_i.new_op ? S_START : S_FIN;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = S_RD;
      end
      S_RD: begin
        state_d = sts_i.scan_end ? S_ENDP : S_EV;
      end
      S_EV: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_w2 ? S_W2 : S_RD;
      end
      S_W2: begin
        cmd_o.w2 = 1'b1;
        state_d  = S_RD;
      end
      S_ENDP: begin
        cmd_o.end_part = 1'b1;
        if (sts_i.wrap && !part_q) begin
          part_d  = 1'b1;
          state_d = S_START;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      part_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      part_q  <= part_d;
    end
  end

endmodule

// ===== src/aroc_dp.sv =====
`timescale 1ns / 1ps

module aroc_dp #(
  parameter int unsigned CAPACITY = aroc_pkg::CapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aroc_pkg::in_item_t  in_data_i,
  output aroc_pkg::out_item_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  aroc_pkg::ctrl_cmd_t cmd_i,
  output aroc_pkg::ctrl_sts_t sts_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // two banks: the current list is read from one, the merged list written to the other
  logic [63:0] mem0 [CAPACITY];
  logic [63:0] mem1 [CAPACITY];

  aroc_pkg::in_item_t  in_q;
  aroc_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                sel_q;
  logic [CW-1:0]       cnt_q, r_q, w_q;
  logic [31:0]         ps_q, pe_q, cs_q, ce_q;
  logic                done_q, ovl_q, hid_q, vis_q, drp_q;
  logic [63:0]         rd0_q, rd1_q, hold_q;

  logic [63:0] rd;
  logic [31:0] lo, hi;
  logic        is_add, wrap, below, after, hit, full_drop;
  logic        we;
  logic [CW-1:0] wa;
  logic [63:0] wd;

  assign rd     = sel_q ? rd1_q : rd0_q;
  assign lo     = rd[63:32];
  assign hi     = rd[31:0];
  assign is_add = (in_q.cmd == aroc_pkg::CMD_ADD);
  assign wrap   = (in_q.start_angle > in_q.end_angle);
  assign below  = (hi < cs_q);
  assign after  = (lo > ce_q);
  assign hit    = ((pe_q == 32'd0) && (r_q == '0) && (lo == 32'd0)) ||
                  ((lo < pe_q) && (ps_q >= lo) && (pe_q <= hi));
  assign full_drop = !ovl_q && (cnt_q == CW'(CAPACITY));

  assign sts_o.new_op   = (in_data_i.cmd == aroc_pkg::CMD_ADD) ||
                          (in_data_i.cmd == aroc_pkg::CMD_CHECK);
  assign sts_o.wrap     = wrap;
  assign sts_o.scan_end = (r_q == cnt_q);
  assign sts_o.need_w2  = is_add && !done_q && !below && after && !full_drop;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  // pick the write into the spare bank
  always_comb begin
    we = 1'b0;
    wd = {cs_q, ce_q};
    if (cmd_i.eval && is_add) begin
      if (done_q || below) begin
        we = 1'b1;
        wd = rd;
      end else if (after && !full_drop) begin
        we = 1'b1;
      end
    end else if (cmd_i.w2) begin
      we = 1'b1;
      wd = hold_q;
    end else if (cmd_i.end_part && is_add && !done_q && !full_drop) begin
      we = 1'b1;
    end
    // drop writes past the end of a full list
    if (w_q >= CW'(CAPACITY)) begin
      we = 1'b0;
    end
  end

  assign wa = w_q;

  // memories
  always_ff @(posedge clk_i) begin
    rd0_q <= mem0[r_q[AW-1:0]];
    rd1_q <= mem1[r_q[AW-1:0]];
    if (we && sel_q) begin
      mem0[wa[AW-1:0]] <= wd;
    end
    if (we && !sel_q) begin
      mem1[wa[AW-1:0]] <= wd;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q  <= in_data_i;
      vis_q <= 1'b0;
      drp_q <= 1'b0;
    end
    if (cmd_i.start) begin
      ps_q   <= cmd_i.part ? 32'd0 : in_q.start_angle;
      pe_q   <= (!cmd_i.part && wrap) ? 32'hFFFF_FFFF : in_q.end_angle;
      cs_q   <= cmd_i.part ? 32'd0 : in_q.start_angle;
      ce_q   <= (!cmd_i.part && wrap) ? 32'hFFFF_FFFF : in_q.end_angle;
      r_q    <= '0;
      w_q    <= '0;
      done_q <= 1'b0;
      ovl_q  <= 1'b0;
      hid_q  <= 1'b0;
    end
    if (cmd_i.eval) begin
      r_q <= r_q + 1'b1;
      if (is_add) begin
        if (done_q || below) begin
          w_q <= w_q + 1'b1;
        end else if (after) begin
          // with room, insert the new entry ahead of this one; with no room, leave the list untouched
          if (!full_drop) begin
            w_q    <= w_q + 1'b1;
            hold_q <= rd;
            done_q <= 1'b1;
          end
        end else begin
          cs_q  <= (lo < cs_q) ? lo : cs_q;
          ce_q  <= (hi > ce_q) ? hi : ce_q;
          ovl_q <= 1'b1;
        end
      end else if (hit) begin
        hid_q <= 1'b1;
      end
    end
    if (cmd_i.w2) begin
      w_q <= w_q + 1'b1;
    end
    if (cmd_i.end_part && !is_add && !hid_q) begin
      vis_q <= 1'b1;
    end
    if (cmd_i.end_part && is_add && !done_q && full_drop) begin
      drp_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      out_q.visible     <= vis_q;
      out_q.dropped     <= drp_q;
      out_q.range_count <= aroc_pkg::CountW'(cnt_q);
    end
  end

  // control state: bank select, count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && (in_data_i.cmd == aroc_pkg::CMD_CLEAR)) begin
        cnt_q <= '0;
      end
      if (cmd_i.end_part && is_add && !(!done_q && full_drop)) begin
        sel_q <= !sel_q;
        cnt_q <= w_q + CW'(!done_q);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/aroc_checker.sv =====
`timescale 1ns / 1ps

module aroc_checker #(
  parameter int unsigned CAPACITY = aroc_pkg::CapacityDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input aroc_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input aroc_pkg::out_item_t out_data_o
);

  // a pending result holds until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // count never exceeds capacity
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.range_count) <= CAPACITY))
    else $error("range count above capacity");

  // a result is either a visibility answer or a drop flag
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.visible && out_data_o.dropped))
    else $error("visible and dropped both set");

endmodule

bind angle_range_occlusion_clipper aroc_checker #(
  .CAPACITY (CAPACITY)
) u_aroc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/angle_range_occlusion_clipper_test.sv =====
`timescale 1ns / 1ps

module angle_range_occlusion_clipper_test;

  localparam int unsigned Cap = aroc_pkg::CapacityDef;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [31:0] AngMax = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  aroc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aroc_pkg::out_item_t out_data;

  angle_range_occlusion_clipper u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the clip list
  logic [31:0] span_lo [Cap+1];
  logic [31:0] span_hi [Cap+1];
  int unsigned span_cnt;

  aroc_pkg::out_item_t pending_q[$];
  bit failed = 1'b0;
  bit stim_done = 1'b0;

  function automatic void span_remove(int unsigned idx);
    for (int unsigned k = idx; k + 1 < span_cnt; k++) begin
      span_lo[k] = span_lo[k+1];
      span_hi[k] = span_hi[k+1];
    end
    span_cnt--;
  endfunction

  function automatic bit span_visible(logic [31:0] s, logic [31:0] e);
    if (e == 0 && span_cnt > 0 && span_lo[0] == 0) return 1'b0;
    for (int unsigned i = 0; i < span_cnt && span_lo[i] < e; i++) begin
      if (s >= span_lo[i] && e <= span_hi[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // merge one non-wrapping span; returns 1 when it was lost for lack of room
  function automatic bit span_merge(logic [31:0] s, logic [31:0] e);
    int unsigned i;
    int unsigned j;
    logic [31:0] ns;
    logic [31:0] ne;
    i = 0;
    while (i < span_cnt && span_lo[i] < e) begin
      if (span_lo[i] >= s && span_hi[i] <= e) span_remove(i);
      else if (span_lo[i] <= s && span_hi[i] >= e) return 1'b0;
      else i++;
    end
    for (i = 0; i < span_cnt && span_lo[i] <= e; i++) begin
      if (span_hi[i] >= s) begin
        ns = (span_lo[i] > s) ? s : span_lo[i];
        ne = (span_hi[i] < e) ? e : span_hi[i];
        j = i + 1;
        while (j < span_cnt && span_lo[j] <= ne) begin
          if (span_hi[j] > ne) ne = span_hi[j];
          span_remove(j);
        end
        span_lo[i] = ns;
        span_hi[i] = ne;
        return 1'b0;
      end
    end
    if (span_cnt >= Cap) return 1'b1;
    i = 0;
    while (i < span_cnt && span_lo[i] < e) i++;
    for (int unsigned k = span_cnt; k > i; k--) begin
      span_lo[k] = span_lo[k-1];
      span_hi[k] = span_hi[k-1];
    end
    span_lo[i] = s;
    span_hi[i] = e;
    span_cnt++;
    return 1'b0;
  endfunction

  function automatic aroc_pkg::out_item_t clip_predict(aroc_pkg::in_item_t it);
    aroc_pkg::out_item_t r;
    r = '0;
    case (it.cmd)
      aroc_pkg::CMD_CLEAR: span_cnt = 0;
      aroc_pkg::CMD_ADD: begin
        if (it.start_angle > it.end_angle) begin
          r.dropped = span_merge(it.start_angle, AngMax);
          if (span_merge(32'd0, it.end_angle)) r.dropped = 1'b1;
        end else begin
          r.dropped = span_merge(it.start_angle, it.end_angle);
        end
      end
      aroc_pkg::CMD_CHECK: begin
        if (it.start_angle > it.end_angle)
          r.visible = span_visible(it.start_angle, AngMax) || span_visible(32'd0, it.end_angle);
        else
          r.visible = span_visible(it.start_angle, it.end_angle);
      end
      default: ;
    endcase
    r.range_count = span_cnt[aroc_pkg::CountW-1:0];
    return r;
  endfunction

  // directed rows; chk marks rows whose result is typed in
  typedef struct {
    logic [1:0]          cmd;
    logic [31:0]         s;
    logic [31:0]         e;
    bit                  chk;
    aroc_pkg::out_item_t res;
  } row_t;

  row_t dir_rows[$] = '{
    '{aroc_pkg::CMD_CHECK, 32'd0,         AngMax,        1, '{1'b1, 1'b0, 10'd0}},
    '{CMD_UNUSED,          AngMax,        AngMax,        1, '{1'b0, 1'b0, 10'd0}},
    '{aroc_pkg::CMD_ADD,   32'd0,         32'd100,       1, '{1'b0, 1'b0, 10'd1}},
    '{aroc_pkg::CMD_CHECK, 32'd10,        32'd0,         0, '0},
    '{aroc_pkg::CMD_CHECK, 32'd5,         32'd0,         0, '0},
    '{aroc_pkg::CMD_CHECK, 32'd0,         32'd100,       0, '0},
    '{aroc_pkg::CMD_CHECK, 32'd0,         32'd101,       0, '0},
    '{aroc_pkg::CMD_ADD,   32'd100,       32'd200,       0, '0},
    '{aroc_pkg::CMD_ADD,   32'd300,       32'd400,       0, '0},
    '{aroc_pkg::CMD_ADD,   32'd250,       32'd500,       0, '0},
    '{aroc_pkg::CMD_ADD,   32'hFFFF_FF00, 32'd20,        0, '0},
    '{aroc_pkg::CMD_CHECK, 32'hFFFF_FFF0, 32'd5,         0, '0},
    '{aroc_pkg::CMD_CHECK, 32'hFFFF_FFF0, 32'd600,       0, '0},
    '{aroc_pkg::CMD_CHECK, 32'd300,       32'd300,       0, '0},
    '{aroc_pkg::CMD_ADD,   32'd0,         AngMax,        0, '0},
    '{aroc_pkg::CMD_CHECK, AngMax,        32'd0,         0, '0},
    '{aroc_pkg::CMD_CLEAR, AngMax,        32'd0,         1, '{1'b0, 1'b0, 10'd0}},
    '{aroc_pkg::CMD_ADD,   AngMax,        AngMax,        0, '0},
    '{aroc_pkg::CMD_CHECK, 32'h5555_5555, 32'hAAAA_AAAA, 0, '0},
    '{aroc_pkg::CMD_CLEAR, 32'd0,         32'd0,         1, '{1'b0, 1'b0, 10'd0}}
  };

  task automatic send_item(aroc_pkg::in_item_t it, bit chk, aroc_pkg::out_item_t res);
    aroc_pkg::out_item_t p;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    p = clip_predict(it);
    if (chk && p !== res)
      $display("%0t: typed result %h disagrees with prediction %h", $time, res, p);
    pending_q.push_back(chk ? res : p);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_angle(int unsigned scale);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return AngMax;
      2: return $urandom;
      default: return $urandom_range(0, scale);
    endcase
  endfunction

  // stimulus
  initial begin
    aroc_pkg::in_item_t it;
    int unsigned burst;
    int unsigned scale;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    span_cnt = 0;
    foreach (dir_rows[r]) begin
      it.cmd = dir_rows[r].cmd;
      it.start_angle = dir_rows[r].s;
      it.end_angle = dir_rows[r].e;
      send_item(it, dir_rows[r].chk, dir_rows[r].res);
    end
    // fill to capacity to reach the full-list drop
    for (int unsigned n = 0; n < Cap + 3; n++) begin
      it.cmd = aroc_pkg::CMD_ADD;
      it.start_angle = n * 4 + 1;
      it.end_angle = n * 4 + 2;
      send_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;
    // hold off until the block has drained
    while (pending_q.size() != 0) @(negedge clk);
    for (int unsigned n = 0; n < 45; n++) begin
      if (burst == 0) begin
        sender_gap();
        burst = $urandom_range(1, 20);
      end
      burst--;
      scale = ($urandom_range(0, 1)) ? 2000 : AngMax;
      it.cmd = ($urandom_range(0, 30) == 0) ? aroc_pkg::CMD_CLEAR :
               ($urandom_range(0, 40) == 0) ? CMD_UNUSED :
               ($urandom_range(0, 1)) ? aroc_pkg::CMD_ADD : aroc_pkg::CMD_CHECK;
      it.start_angle = rand_angle(scale);
      it.end_angle = ($urandom_range(0, 3) == 0) ? rand_angle(scale) :
                     it.start_angle + $urandom_range(0, 300);
      send_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if ($urandom_range(0, 99) < 40) out_ready <= ($urandom_range(0, 2) != 0);
  end

  // result checking
  always @(posedge clk) begin
    aroc_pkg::out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failed = 1'b1;
      end else begin
        exp_res = pending_q.pop_front();
        if (out_data.visible !== exp_res.visible || out_data.dropped !== exp_res.dropped ||
            out_data.range_count !== exp_res.range_count) begin
          $display("%0t: expected vis %b drop %b count %0d, got vis %b drop %b count %0d",
                   $time, exp_res.visible, exp_res.dropped, exp_res.range_count,
                   out_data.visible, out_data.dropped, out_data.range_count);
          failed = 1'b1;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done && pending_q.size() == 0);
    repeat (4 * Cap + 50) @(posedge clk);
    if (!failed && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/aroc_pkg.sv
src/aroc_ctrl.sv
src/aroc_dp.sv
src/angle_range_occlusion_clipper.sv
src/aroc_checker.sv
tb/angle_range_occlusion_clipper_test.sv
